// ----- design/assert_macros.svh -----
// Assertion macros for the motor drive supervisor; msup_ctrl uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/msup_pkg.sv -----
// Types, codes and constants of the motor drive supervisor.
package msup_pkg;

	localparam int CAL_SAMPLES = 1024;
	localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES);
	localparam int ADC_BITS    = 12;
	localparam int ACC_W       = 22;
	localparam int CNT_W       = 11;
	localparam int TICK_W      = 20;
	localparam logic [TICK_W-1:0] TICKS_MAX = '1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [19:0] ALIGN_LEN_RST        = 20'd20000;
	localparam logic [14:0] SPEED_REF_LIMIT_RST  = 15'd16384;
	localparam logic [14:0] RAMP_STEP_RST        = 15'd1;
	localparam logic [7:0]  SPEED_DIVIDER_RST    = 8'd10;
	localparam logic [14:0] WEAKEN_THRESHOLD_RST = 15'd13107;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALIGN_LEN        = 3'd0,
		REG_SPEED_REF_LIMIT  = 3'd1,
		REG_RAMP_STEP        = 3'd2,
		REG_SPEED_DIVIDER    = 3'd3,
		REG_WEAKEN_THRESHOLD = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_TICK      = 3'd0,
		KIND_RUN       = 3'd1,
		KIND_STOP      = 3'd2,
		KIND_SET_REF   = 3'd3,
		KIND_RAISE_FLT = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		MODE_CAL   = 3'd0,
		MODE_IDLE  = 3'd1,
		MODE_ALIGN = 3'd2,
		MODE_RUN   = 3'd3,
		MODE_FAULT = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic [ADC_BITS-1:0] raw_a;
		logic [ADC_BITS-1:0] raw_b;
		logic [ADC_BITS-1:0] raw_c;
		logic                driver_fault;
		logic signed [15:0]  measured_speed;
		logic signed [15:0]  speed_request;
		logic [7:0]          fault_bits;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic               pwm_enable;
		logic               loop_reset;
		logic               encoder_zero;
		logic               speed_loop_strobe;
		logic signed [15:0] speed_ramp;
		logic               weaken_enable;
		logic               offsets_valid;
		logic [11:0]        offset_a;
		logic [11:0]        offset_b;
		logic [11:0]        offset_c;
		logic [7:0]         fault_latch;
	} rpt_item_t;

	typedef struct packed {
		logic [19:0] align_len;
		logic [14:0] speed_ref_limit;
		logic [14:0] ramp_step;
		logic [7:0]  speed_divider;
		logic [14:0] weaken_threshold;
	} cfg_t;

	// Calibration state as it stands after the current item.
	typedef struct packed {
		logic        done;
		logic        offsets_valid;
		logic [11:0] offset_a;
		logic [11:0] offset_b;
		logic [11:0] offset_c;
	} cal_view_t;

	// Mode controller state and strobes as they stand after the current item.
	typedef struct packed {
		mode_t              mode;
		logic               pwm_enable;
		logic               loop_reset;
		logic               encoder_zero;
		logic               speed_loop_strobe;
		logic signed [15:0] speed_ramp;
		logic               weaken_enable;
		logic [7:0]         fault_latch;
	} ctrl_view_t;

endpackage

// ----- design/msup_if.sv -----
// Valid/ready channels for supervisor commands and reports.
interface msup_cmd_if;
	logic                valid;
	logic                ready;
	msup_pkg::cmd_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface msup_rpt_if;
	logic                valid;
	logic                ready;
	msup_pkg::rpt_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- design/msup_cal.sv -----
// Phase-current zero offset calibration: accumulators, sample count, offsets.
module msup_cal (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          cal_en,
	input  logic [msup_pkg::ADC_BITS-1:0] raw_a,
	input  logic [msup_pkg::ADC_BITS-1:0] raw_b,
	input  logic [msup_pkg::ADC_BITS-1:0] raw_c,
	output msup_pkg::cal_view_t           view
);

	logic [msup_pkg::ACC_W-1:0] acc_a_q, acc_b_q, acc_c_q;
	logic [msup_pkg::ACC_W-1:0] acc_a_n, acc_b_n, acc_c_n;
	logic [msup_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic                       ok_q;
	logic [11:0]                off_a_q, off_b_q, off_c_q;

	assign acc_a_n = acc_a_q + msup_pkg::ACC_W'(raw_a);
	assign acc_b_n = acc_b_q + msup_pkg::ACC_W'(raw_b);
	assign acc_c_n = acc_c_q + msup_pkg::ACC_W'(raw_c);
	assign cnt_n   = cnt_q + 1'b1;

	always_comb begin
		view.done          = (cnt_n >= msup_pkg::CNT_W'(msup_pkg::CAL_SAMPLES));
		view.offsets_valid = ok_q;
		view.offset_a      = off_a_q;
		view.offset_b      = off_b_q;
		view.offset_c      = off_c_q;
		if (cal_en && view.done) begin
			view.offsets_valid = 1'b1;
			// sample count is a power of two: average is a shift
			view.offset_a = acc_a_n[msup_pkg::CAL_SHIFT +: 12];
			view.offset_b = acc_b_n[msup_pkg::CAL_SHIFT +: 12];
			view.offset_c = acc_c_n[msup_pkg::CAL_SHIFT +: 12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
			acc_c_q <= '0;
			cnt_q   <= '0;
			ok_q    <= 1'b0;
			off_a_q <= '0;
			off_b_q <= '0;
			off_c_q <= '0;
		end else if (step && cal_en) begin
			acc_a_q <= acc_a_n;
			acc_b_q <= acc_b_n;
			acc_c_q <= acc_c_n;
			cnt_q   <= cnt_n;
			ok_q    <= view.offsets_valid;
			off_a_q <= view.offset_a;
			off_b_q <= view.offset_b;
			off_c_q <= view.offset_c;
		end
	end

endmodule

// ----- design/msup_ctrl.sv -----
// Mode state machine, speed ramp, outer loop divider and fault latch.
`include "assert_macros.svh"

module msup_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  msup_pkg::cfg_t       cfg,
	input  logic [2:0]           kind,
	input  logic                 driver_fault,
	input  logic signed [15:0]   measured_speed,
	input  logic signed [15:0]   speed_request,
	input  logic [7:0]           fault_bits,
	input  logic                 cal_done,
	output logic                 cal_en,
	output msup_pkg::ctrl_view_t view
);

	msup_pkg::mode_t                 mode_q, mode_n;
	logic [msup_pkg::TICK_W-1:0]     ticks_q, ticks_n;
	logic                            bridge_q, bridge_n;
	logic [7:0]                      fault_q, fault_n;
	logic signed [15:0]              ref_q, ref_n;
	logic signed [15:0]              ramp_q, ramp_n;
	logic [7:0]                      div_q, div_n, div_inc;
	logic signed [16:0]              delta, step_x, ramp_x, ref_x, req_x, lim_x;
	logic [16:0]                     spd_x, spd_mag;
	logic                            drive_mode;

	assign ramp_x  = {ramp_q[15], ramp_q};
	assign ref_x   = {ref_q[15], ref_q};
	assign req_x   = {speed_request[15], speed_request};
	assign step_x  = {2'b00, cfg.ramp_step};
	assign lim_x   = {2'b00, cfg.speed_ref_limit};
	assign delta   = ref_x - ramp_x;
	assign div_inc = div_q + 8'd1;
	assign spd_x   = {measured_speed[15], measured_speed};
	assign spd_mag = measured_speed[15] ? (17'd0 - spd_x) : spd_x;

	assign drive_mode = (mode_q == msup_pkg::MODE_ALIGN) || (mode_q == msup_pkg::MODE_RUN);

	always_comb begin
		mode_n   = mode_q;
		ticks_n  = ticks_q;
		bridge_n = bridge_q;
		fault_n  = fault_q;
		ref_n    = ref_q;
		ramp_n   = ramp_q;
		div_n    = div_q;
		cal_en   = 1'b0;
		view.loop_reset        = 1'b0;
		view.encoder_zero      = 1'b0;
		view.speed_loop_strobe = 1'b0;
		view.weaken_enable     = 1'b0;
		unique case (kind)
			msup_pkg::KIND_TICK: begin
				if (ticks_q != msup_pkg::TICKS_MAX) begin
					ticks_n = ticks_q + 1'b1;
				end
				if (driver_fault && mode_q != msup_pkg::MODE_FAULT) begin
					fault_n[0] = 1'b1;
					bridge_n   = 1'b0;
					mode_n     = msup_pkg::MODE_FAULT;
					ticks_n    = '0;
				end else begin
					unique case (mode_q)
						msup_pkg::MODE_CAL: begin
							cal_en = 1'b1;
							if (cal_done) begin
								mode_n  = msup_pkg::MODE_IDLE;
								ticks_n = '0;
							end
						end
						msup_pkg::MODE_ALIGN: begin
							bridge_n = 1'b1;
							if (ticks_n >= cfg.align_len) begin
								view.encoder_zero = 1'b1;
								view.loop_reset   = 1'b1;
								mode_n            = msup_pkg::MODE_RUN;
								ticks_n           = '0;
							end
						end
						msup_pkg::MODE_RUN: begin
							if (delta > step_x) begin
								ramp_n = 16'(ramp_x + step_x);
							end else if (delta < -step_x) begin
								ramp_n = 16'(ramp_x - step_x);
							end else begin
								ramp_n = ref_q;
							end
							if (div_inc >= cfg.speed_divider) begin
								div_n                  = '0;
								view.speed_loop_strobe = 1'b1;
							end else begin
								div_n = div_inc;
							end
							view.weaken_enable = (spd_mag > {2'b00, cfg.weaken_threshold});
						end
						default: ;
					endcase
				end
			end
			msup_pkg::KIND_RUN: begin
				if (mode_q == msup_pkg::MODE_IDLE) begin
					mode_n  = msup_pkg::MODE_ALIGN;
					ticks_n = '0;
				end
			end
			msup_pkg::KIND_STOP: begin
				view.loop_reset = 1'b1;
				bridge_n        = 1'b0;
				ramp_n          = '0;
				mode_n          = msup_pkg::MODE_IDLE;
				ticks_n         = '0;
			end
			msup_pkg::KIND_SET_REF: begin
				// clamp to +/- limit
				if (req_x > lim_x) begin
					ref_n = 16'(lim_x);
				end else if (req_x < -lim_x) begin
					ref_n = 16'(-lim_x);
				end else begin
					ref_n = speed_request;
				end
			end
			msup_pkg::KIND_RAISE_FLT: begin
				fault_n  = fault_q | fault_bits;
				bridge_n = 1'b0;
				mode_n   = msup_pkg::MODE_FAULT;
				ticks_n  = '0;
			end
			default: ;
		endcase
		view.mode        = mode_n;
		view.pwm_enable  = bridge_n;
		view.speed_ramp  = ramp_n;
		view.fault_latch = fault_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= msup_pkg::MODE_CAL;
			ticks_q  <= '0;
			bridge_q <= 1'b0;
			fault_q  <= '0;
			ref_q    <= '0;
			ramp_q   <= '0;
			div_q    <= '0;
		end else if (step) begin
			mode_q   <= mode_n;
			ticks_q  <= ticks_n;
			bridge_q <= bridge_n;
			fault_q  <= fault_n;
			ref_q    <= ref_n;
			ramp_q   <= ramp_n;
			div_q    <= div_n;
		end
	end

	`ASSERT_IMPLY(a_bridge_mode, clk, arst_n, bridge_q, drive_mode)
	`ASSERT_NEXT(a_zero_enters_run, clk, arst_n, step && view.encoder_zero, mode_q == msup_pkg::MODE_RUN)
	`ASSERT_NEXT(a_faults_stick, clk, arst_n, 1'b1, (fault_q & $past(fault_q)) == $past(fault_q))
	`ASSERT_IMPLY(a_ramp_in_range, clk, arst_n, 1'b1, ramp_q != 16'sh8000 && ref_q != 16'sh8000)

endmodule

// ----- design/motor_drive_supervisor.sv -----
// Top level of the motor drive supervisor: config registers, item and report stages.
//
//   channel  role    handshake      payload
//   cmd      sink    valid/ready    kind, raw phase samples, fault pin, speeds, fault bits
//   report   source  valid/ready    mode, strobes, ramp, weakening, offsets, latched faults
//   cfg      write   cfg_we         cfg_index selects register, cfg_wdata value
//
// One item per cycle sustained while reports are taken; an item taken sits in the
// item register, then the mode logic updates state and loads the report register.
// Reset clears control state, config gets defaults; mode starts in calibrate. A held
// report stalls the item register, and cmd.ready drops only while both stages are full.
module motor_drive_supervisor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [msup_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msup_pkg::CFG_DATA_W-1:0] cfg_wdata,
	msup_cmd_if.sink                        cmd,
	msup_rpt_if.source                      report
);

	msup_pkg::cfg_t      cfg_q;
	msup_pkg::cmd_item_t item_s1;
	logic                valid_s1;
	msup_pkg::rpt_item_t rpt_q;
	logic                rpt_valid_q;
	logic                advance;
	logic                cal_en;
	msup_pkg::cal_view_t  cal_view;
	msup_pkg::ctrl_view_t ctrl_view;

	// advance the item stage when the report register is free or being taken
	assign advance    = valid_s1 && (!rpt_valid_q || report.ready);
	assign cmd.ready  = !valid_s1 || advance;
	assign report.valid = rpt_valid_q;
	assign report.data  = rpt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.align_len        <= msup_pkg::ALIGN_LEN_RST;
			cfg_q.speed_ref_limit  <= msup_pkg::SPEED_REF_LIMIT_RST;
			cfg_q.ramp_step        <= msup_pkg::RAMP_STEP_RST;
			cfg_q.speed_divider    <= msup_pkg::SPEED_DIVIDER_RST;
			cfg_q.weaken_threshold <= msup_pkg::WEAKEN_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msup_pkg::REG_ALIGN_LEN:        cfg_q.align_len        <= cfg_wdata[19:0];
				msup_pkg::REG_SPEED_REF_LIMIT:  cfg_q.speed_ref_limit  <= cfg_wdata[14:0];
				msup_pkg::REG_RAMP_STEP:        cfg_q.ramp_step        <= cfg_wdata[14:0];
				msup_pkg::REG_SPEED_DIVIDER:    cfg_q.speed_divider    <= cfg_wdata[7:0];
				msup_pkg::REG_WEAKEN_THRESHOLD: cfg_q.weaken_threshold <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.data;
		end
	end

	msup_cal u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cal_en (cal_en),
		.raw_a  (item_s1.raw_a),
		.raw_b  (item_s1.raw_b),
		.raw_c  (item_s1.raw_c),
		.view   (cal_view)
	);

	msup_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.cfg            (cfg_q),
		.kind           (item_s1.kind),
		.driver_fault   (item_s1.driver_fault),
		.measured_speed (item_s1.measured_speed),
		.speed_request  (item_s1.speed_request),
		.fault_bits     (item_s1.fault_bits),
		.cal_done       (cal_view.done),
		.cal_en         (cal_en),
		.view           (ctrl_view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (advance) begin
			rpt_valid_q <= 1'b1;
		end else if (report.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rpt_q.mode              <= ctrl_view.mode;
			rpt_q.pwm_enable        <= ctrl_view.pwm_enable;
			rpt_q.loop_reset        <= ctrl_view.loop_reset;
			rpt_q.encoder_zero      <= ctrl_view.encoder_zero;
			rpt_q.speed_loop_strobe <= ctrl_view.speed_loop_strobe;
			rpt_q.speed_ramp        <= ctrl_view.speed_ramp;
			rpt_q.weaken_enable     <= ctrl_view.weaken_enable;
			rpt_q.offsets_valid     <= cal_view.offsets_valid;
			rpt_q.offset_a          <= cal_view.offset_a;
			rpt_q.offset_b          <= cal_view.offset_b;
			rpt_q.offset_c          <= cal_view.offset_c;
			rpt_q.fault_latch       <= ctrl_view.fault_latch;
		end
	end

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the motor drive supervisor: predicts every report and compares it.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [2:0] KIND_UNDEF_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNDEF_LAST  = 3'd7;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [msup_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [msup_pkg::CFG_DATA_W-1:0] cfg_wdata;

	msup_cmd_if cmd_ch();
	msup_rpt_if rpt_ch();

	motor_drive_supervisor DUT (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.cmd(cmd_ch),
		.report(rpt_ch)
	);

	always #5 clk = ~clk;

	// Supervisor model state and its copy of the config registers.
	msup_pkg::cfg_t                cfg;
	msup_pkg::mode_t               st_mode;
	logic [msup_pkg::TICK_W-1:0]   st_ticks;
	logic [msup_pkg::ACC_W-1:0]    acc_a, acc_b, acc_c;
	logic [msup_pkg::CNT_W-1:0]    cal_cnt;
	logic signed [15:0]            st_ref, st_ramp;
	logic [7:0]                    div_cnt;
	logic                          bridge;
	logic [7:0]                    faults;
	logic [11:0]                   off_a, off_b, off_c;
	logic                          off_ok;

	msup_pkg::rpt_item_t pending_reports[$];
	msup_pkg::rpt_item_t want_rpt;
	int        mismatch_count = 0;
	int        reports_checked = 0;
	int        items_sent = 0;
	int        cycle_count = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;
	int        sink_hold = 0;

	task automatic flag_error(string msg);
		if (mismatch_count < 100)
			$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want)
			flag_error($sformatf("report %0d %s: expected %h, got %h",
				reports_checked, name, want, got));
	endtask

	function automatic void enter_mode(msup_pkg::mode_t m);
		st_mode  = m;
		st_ticks = '0;
	endfunction

	// Advance the model by one item and return the report it causes.
	function automatic msup_pkg::rpt_item_t supervise_step(msup_pkg::cmd_item_t c);
		msup_pkg::rpt_item_t r;
		int step, level, delta, spd, v, lim;
		r = '0;
		case (c.kind)
			msup_pkg::KIND_TICK: begin
				if (st_ticks != msup_pkg::TICKS_MAX)
					st_ticks = st_ticks + 1'b1;
				if (c.driver_fault && st_mode != msup_pkg::MODE_FAULT) begin
					faults[0] = 1'b1;
					bridge = 1'b0;
					enter_mode(msup_pkg::MODE_FAULT);
				end
				case (st_mode)
					msup_pkg::MODE_CAL: begin
						acc_a = acc_a + c.raw_a;
						acc_b = acc_b + c.raw_b;
						acc_c = acc_c + c.raw_c;
						cal_cnt = cal_cnt + 1'b1;
						if (cal_cnt >= msup_pkg::CAL_SAMPLES) begin
							off_a = 12'(acc_a >> msup_pkg::CAL_SHIFT);
							off_b = 12'(acc_b >> msup_pkg::CAL_SHIFT);
							off_c = 12'(acc_c >> msup_pkg::CAL_SHIFT);
							off_ok = 1'b1;
							enter_mode(msup_pkg::MODE_IDLE);
						end
					end
					msup_pkg::MODE_ALIGN: begin
						bridge = 1'b1;
						if (st_ticks >= cfg.align_len) begin
							r.encoder_zero = 1'b1;
							r.loop_reset = 1'b1;
							enter_mode(msup_pkg::MODE_RUN);
						end
					end
					msup_pkg::MODE_RUN: begin
						step  = int'(cfg.ramp_step);
						level = int'(st_ramp);
						delta = int'(st_ref) - level;
						if (delta > step)
							level = level + step;
						else if (delta < -step)
							level = level - step;
						else
							level = int'(st_ref);
						st_ramp = level[15:0];
						div_cnt = div_cnt + 8'd1;
						if (div_cnt >= cfg.speed_divider) begin
							div_cnt = '0;
							r.speed_loop_strobe = 1'b1;
						end
						spd = $signed(c.measured_speed);
						if (spd < 0)
							spd = -spd;
						r.weaken_enable = (spd > int'(cfg.weaken_threshold));
					end
					default: ;
				endcase
			end
			msup_pkg::KIND_RUN: begin
				if (st_mode == msup_pkg::MODE_IDLE)
					enter_mode(msup_pkg::MODE_ALIGN);
			end
			msup_pkg::KIND_STOP: begin
				r.loop_reset = 1'b1;
				bridge = 1'b0;
				st_ramp = '0;
				enter_mode(msup_pkg::MODE_IDLE);
			end
			msup_pkg::KIND_SET_REF: begin
				v = $signed(c.speed_request);
				lim = int'(cfg.speed_ref_limit);
				if (v > lim)
					v = lim;
				if (v < -lim)
					v = -lim;
				st_ref = v[15:0];
			end
			msup_pkg::KIND_RAISE_FLT: begin
				faults = faults | c.fault_bits;
				bridge = 1'b0;
				enter_mode(msup_pkg::MODE_FAULT);
			end
			default: ;
		endcase
		r.mode          = st_mode;
		r.pwm_enable    = bridge;
		r.speed_ramp    = st_ramp;
		r.offsets_valid = off_ok;
		r.offset_a      = off_a;
		r.offset_b      = off_b;
		r.offset_c      = off_c;
		r.fault_latch   = faults;
		return r;
	endfunction

	function automatic int source_gap();
		if (src_idle_pct == 0 || $urandom_range(99) >= src_idle_pct)
			return 0;
		return ($urandom_range(19) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
	endfunction

	function automatic msup_pkg::cmd_item_t make_cmd(logic [2:0] kind);
		msup_pkg::cmd_item_t c;
		c.kind           = kind;
		c.raw_a          = 12'($urandom);
		c.raw_b          = 12'($urandom);
		c.raw_c          = 12'($urandom);
		c.driver_fault   = 1'b0;
		c.measured_speed = 16'($urandom);
		c.speed_request  = 16'($urandom);
		c.fault_bits     = 8'($urandom);
		return c;
	endfunction

	// Mix speeds around the weakening threshold with extremes and noise.
	function automatic logic [15:0] pick_speed();
		int v;
		case ($urandom_range(3))
			0: begin
				v = int'(cfg.weaken_threshold) + int'($urandom_range(2)) - 1;
				if ($urandom_range(1))
					v = -v;
			end
			1: v = $urandom_range(1) ? 32767 : -32768;
			default: v = int'($urandom);
		endcase
		return v[15:0];
	endfunction

	function automatic logic [15:0] pick_ref();
		int v;
		case ($urandom_range(3))
			0: v = int'(cfg.speed_ref_limit) + int'($urandom_range(1));
			1: v = int'($urandom_range(400)) - 200;
			default: v = int'($urandom);
		endcase
		if ($urandom_range(1))
			v = -v;
		return v[15:0];
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_cmd(msup_pkg::cmd_item_t c);
		int gap;
		gap = source_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pending_reports.push_back(supervise_step(c));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_tick(logic [15:0] speed, logic drv_fault);
		msup_pkg::cmd_item_t c;
		c = make_cmd(msup_pkg::KIND_TICK);
		c.measured_speed = speed;
		c.driver_fault = drv_fault;
		send_cmd(c);
	endtask

	// arg is the speed request for a set reference, its low byte the fault bits.
	task automatic send_req(logic [2:0] kind, logic [15:0] arg);
		msup_pkg::cmd_item_t c;
		c = make_cmd(kind);
		c.speed_request = arg;
		c.fault_bits = arg[7:0];
		send_cmd(c);
	endtask

	task automatic wait_reports_done();
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(msup_pkg::reg_idx_t idx, logic [msup_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			msup_pkg::REG_ALIGN_LEN:        cfg.align_len = val;
			msup_pkg::REG_SPEED_REF_LIMIT:  cfg.speed_ref_limit = val[14:0];
			msup_pkg::REG_RAMP_STEP:        cfg.ramp_step = val[14:0];
			msup_pkg::REG_SPEED_DIVIDER:    cfg.speed_divider = val[7:0];
			msup_pkg::REG_WEAKEN_THRESHOLD: cfg.weaken_threshold = val[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_idle(int src, int sink);
		src_idle_pct = src;
		sink_stall_pct = sink;
	endtask

	// Feed the calibration window with requests it must ignore or merely record.
	task automatic test_calibration();
		msup_pkg::cmd_item_t c;
		int i;
		set_idle(20, 20);
		for (i = 0; i < msup_pkg::CAL_SAMPLES; i++) begin
			if (i % 128 == 5) begin
				case ((i / 128) % 3)
					0: c = make_cmd(msup_pkg::KIND_RUN);
					1: begin
						c = make_cmd(msup_pkg::KIND_SET_REF);
						c.speed_request = (i < 512) ? 16'h7FFF : 16'h8000;
					end
					default: c = make_cmd(3'($urandom_range(KIND_UNDEF_LAST, KIND_UNDEF_FIRST)));
				endcase
				send_cmd(c);
			end
			c = make_cmd(msup_pkg::KIND_TICK);
			if (i == 0)
				{c.raw_a, c.raw_b, c.raw_c} = '1;
			else if (i == 1)
				{c.raw_a, c.raw_b, c.raw_c} = '0;
			send_cmd(c);
		end
	endtask

	task automatic test_mode_sequence();
		wait_reports_done();
		write_reg(msup_pkg::REG_ALIGN_LEN, 20'd2);
		set_idle(30, 30);
		send_req(msup_pkg::KIND_SET_REF, 16'h7FFF);
		send_req(msup_pkg::KIND_SET_REF, 16'h8000);
		send_req(msup_pkg::KIND_RUN, '0);
		send_tick('0, 1'b0);
		send_tick('0, 1'b0);
		send_tick(16'h7FFF, 1'b0);
		send_tick(16'h8000, 1'b0);
		send_tick(16'd13107, 1'b0);
		send_tick(-16'sd13108, 1'b0);
		send_req(msup_pkg::KIND_RUN, '0);
		send_req(KIND_UNDEF_LAST, '0);
		send_tick('0, 1'b1);
		send_req(msup_pkg::KIND_RUN, '0);
		send_req(msup_pkg::KIND_RAISE_FLT, 16'h0080);
		send_tick('0, 1'b1);
		send_req(msup_pkg::KIND_STOP, '0);
		send_tick('0, 1'b1);
		send_req(msup_pkg::KIND_STOP, '0);
		send_req(msup_pkg::KIND_RAISE_FLT, 16'h0000);
		send_req(msup_pkg::KIND_STOP, '0);
	endtask

	// Zero step holds the ramp, zero divider strobes every tick, zero align leaves at once.
	task automatic test_zero_settings();
		wait_reports_done();
		write_reg(msup_pkg::REG_RAMP_STEP, '0);
		write_reg(msup_pkg::REG_SPEED_DIVIDER, '0);
		write_reg(msup_pkg::REG_ALIGN_LEN, '0);
		send_req(msup_pkg::KIND_SET_REF, 16'd5000);
		send_req(msup_pkg::KIND_RUN, '0);
		send_tick('0, 1'b0);
		send_tick('0, 1'b0);
		send_tick('0, 1'b0);
		wait_reports_done();
		write_reg(msup_pkg::REG_SPEED_REF_LIMIT, '0);
		write_reg(msup_pkg::REG_WEAKEN_THRESHOLD, '0);
		send_req(msup_pkg::KIND_SET_REF, -16'sd20000);
		send_tick('0, 1'b0);
		send_tick(16'd1, 1'b0);
		send_req(msup_pkg::KIND_STOP, '0);
	endtask

	// One drive cycle: stop, optional reference, run, align, run ticks, then shut down.
	task automatic random_session();
		msup_pkg::cmd_item_t c;
		int n_ticks, pick;
		send_req(msup_pkg::KIND_STOP, '0);
		if ($urandom_range(1))
			send_req(msup_pkg::KIND_SET_REF, pick_ref());
		send_req(msup_pkg::KIND_RUN, '0);
		n_ticks = (cfg.align_len == 0) ? 1 : cfg.align_len;
		if (n_ticks > 60)
			n_ticks = 60;
		n_ticks = n_ticks + $urandom_range(40, 3);
		repeat (n_ticks) begin
			send_tick(pick_speed(), $urandom_range(99) == 0);
			if ($urandom_range(9) == 0)
				send_req(msup_pkg::KIND_SET_REF, pick_ref());
		end
		pick = $urandom_range(9);
		if (pick < 2) begin
			send_req(msup_pkg::KIND_RAISE_FLT, 16'($urandom));
		end else if (pick < 4) begin
			send_tick(pick_speed(), 1'b1);
		end else begin
			c = make_cmd(msup_pkg::KIND_STOP);
			send_cmd(c);
		end
	endtask

	task automatic random_phase(msup_pkg::cfg_t s, int src, int sink, int n_items);
		msup_pkg::cmd_item_t c;
		int stop_at;
		wait_reports_done();
		write_reg(msup_pkg::REG_ALIGN_LEN, s.align_len);
		write_reg(msup_pkg::REG_SPEED_REF_LIMIT, 20'(s.speed_ref_limit));
		write_reg(msup_pkg::REG_RAMP_STEP, 20'(s.ramp_step));
		write_reg(msup_pkg::REG_SPEED_DIVIDER, 20'(s.speed_divider));
		write_reg(msup_pkg::REG_WEAKEN_THRESHOLD, 20'(s.weaken_threshold));
		set_idle(src, sink);
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(9) == 0) begin
				c = make_cmd(3'($urandom_range(7)));
				c.driver_fault = ($urandom_range(3) == 0);
				c.measured_speed = pick_speed();
				send_cmd(c);
			end else begin
				random_session();
			end
		end
	endtask

	task automatic test_random_settings();
		random_phase('{20'd1, 15'h7FFF, 15'h7FFF, 8'd1, 15'd0}, 0, 0, 170);
		random_phase('{20'($urandom_range(30)), 15'($urandom), 15'($urandom_range(2000, 1)),
			8'($urandom_range(20, 1)), 15'($urandom)}, 30, 30, 170);
		random_phase('{20'd0, 15'd0, 15'd0, 8'd255, 15'h7FFF}, 10, 50, 120);
		random_phase('{20'hFFFFF, 15'($urandom), 15'($urandom), 8'd0, 15'($urandom)},
			20, 20, 40);
		random_phase('{20'($urandom_range(12)), 15'($urandom), 15'($urandom_range(300, 1)),
			8'($urandom_range(8, 1)), 15'($urandom)}, 15, 25, 150);
	endtask

	// Report sink: ready drops for random stretches, mostly short.
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			rpt_ch.ready <= 1'b0;
			sink_hold--;
		end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
			rpt_ch.ready <= 1'b0;
			sink_hold = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
		end else begin
			rpt_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rpt_ch.valid && rpt_ch.ready) begin
			if (pending_reports.size() == 0) begin
				flag_error("report with no item outstanding");
			end else begin
				want_rpt = pending_reports.pop_front();
				check_field("mode", 16'(want_rpt.mode), 16'(rpt_ch.data.mode));
				check_field("pwm_enable", 16'(want_rpt.pwm_enable),
					16'(rpt_ch.data.pwm_enable));
				check_field("loop_reset", 16'(want_rpt.loop_reset),
					16'(rpt_ch.data.loop_reset));
				check_field("encoder_zero", 16'(want_rpt.encoder_zero),
					16'(rpt_ch.data.encoder_zero));
				check_field("speed_loop_strobe", 16'(want_rpt.speed_loop_strobe),
					16'(rpt_ch.data.speed_loop_strobe));
				check_field("speed_ramp", want_rpt.speed_ramp, rpt_ch.data.speed_ramp);
				check_field("weaken_enable", 16'(want_rpt.weaken_enable),
					16'(rpt_ch.data.weaken_enable));
				check_field("offsets_valid", 16'(want_rpt.offsets_valid),
					16'(rpt_ch.data.offsets_valid));
				check_field("offset_a", 16'(want_rpt.offset_a), 16'(rpt_ch.data.offset_a));
				check_field("offset_b", 16'(want_rpt.offset_b), 16'(rpt_ch.data.offset_b));
				check_field("offset_c", 16'(want_rpt.offset_c), 16'(rpt_ch.data.offset_c));
				check_field("fault_latch", 16'(want_rpt.fault_latch),
					16'(rpt_ch.data.fault_latch));
				reports_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		rpt_ch.ready = 1'b0;
		cfg = '{msup_pkg::ALIGN_LEN_RST, msup_pkg::SPEED_REF_LIMIT_RST,
			msup_pkg::RAMP_STEP_RST, msup_pkg::SPEED_DIVIDER_RST,
			msup_pkg::WEAKEN_THRESHOLD_RST};
		st_mode = msup_pkg::MODE_CAL;
		st_ticks = '0;
		{acc_a, acc_b, acc_c, cal_cnt} = '0;
		{st_ref, st_ramp, div_cnt, bridge, faults} = '0;
		{off_a, off_b, off_c, off_ok} = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_calibration();
		test_mode_sequence();
		test_zero_settings();
		test_random_settings();

		wait_reports_done();
		repeat (8) @(negedge clk);
		if (pending_reports.size() != 0)
			flag_error($sformatf("%0d reports never arrived", pending_reports.size()));
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
